FILE: rtl/hpack_pkg.sv
// Package for the HPACK Huffman decoder: result kinds, controller states,
// command/status structs and the RFC 7541 code table lookup. No dependencies.
`timescale 1ns / 1ps
package hpack_pkg;

    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 30;
    localparam int CNT_W   = 5;
    localparam int SYM_W   = 9;
    localparam int BIT_W   = 3;
    localparam int EOS_SYM = 256;
    localparam int PAD_MIN = 8;

    typedef enum logic [1:0] {
        KIND_SYMBOL  = 2'd0,
        KIND_DONE_OK = 2'd1,
        KIND_EOS_ERR = 2'd2,
        KIND_PAD_ERR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT,
        ST_STATUS,
        ST_WAIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic shift;      // push next bit into pending word
        logic clr;        // clear pending word
        logic set_disc;   // enter discard mode
        logic clr_disc;   // leave discard mode
        logic out_load;   // load output register
        kind_t out_kind;
        logic use_sym;    // take symbol from match
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic disc;
        logic fin;
        logic match;
        logic is_eos;
        logic full;
        logic last_bit;
        logic pad_err;
    } sts_t;

    localparam logic [PEND_W-1:0] CODE_VAL [257] = '{
        30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
        30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,
        30'h3ffffffd,30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,
        30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,
        30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,
        30'hffffffb,30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
        30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
        30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
        30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
        30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
        30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
        30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
        30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
        30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
        30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
        30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
        30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
        30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
        30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
        30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
        30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
        30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
        30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
        30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
        30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
        30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
        30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,30'h1ffffed,
        30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,30'hfffff2,
        30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,30'h7ffffe5,
        30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
        30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,30'h7ffff4,
        30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,30'h7ffffea,
        30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,30'h3ffffee,
        30'h3fffffff
    };

    localparam logic [CNT_W-1:0] CODE_LEN [257] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26,
        5'd30
    };

    function automatic logic [SYM_W:0] long_lookup(input logic [PEND_W-1:0] bits,
                                                   input logic [CNT_W-1:0] cnt);
        logic [SYM_W:0] r;
        r = '0;
        for (int s = 0; s < 257; s++) begin
            if (CODE_LEN[s] == cnt && CODE_VAL[s] == bits)
                r = {1'b1, SYM_W'(s)};
        end
        return r;
    endfunction

    // Match the pending word against the full code; returns {hit, symbol}.
    function automatic logic [SYM_W:0] code_lookup(input logic [PEND_W-1:0] bits,
                                                   input logic [CNT_W-1:0] cnt);
        logic [SYM_W:0] r;
        r = '0;
        case (cnt)
            5'd5: begin
                case (bits[4:0])
                    5'h0: r = {1'b1, 9'd48}; 5'h1: r = {1'b1, 9'd49};
                    5'h2: r = {1'b1, 9'd50}; 5'h3: r = {1'b1, 9'd97};
                    5'h4: r = {1'b1, 9'd99}; 5'h5: r = {1'b1, 9'd101};
                    5'h6: r = {1'b1, 9'd105}; 5'h7: r = {1'b1, 9'd111};
                    5'h8: r = {1'b1, 9'd115}; 5'h9: r = {1'b1, 9'd116};
                    default: r = '0;
                endcase
            end
            default: r = long_lookup(bits, cnt);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/hpack_dp.sv
// Datapath of the HPACK Huffman decoder: byte shifter, pending code word,
// table match, discard flag and output register. Depends on hpack_pkg.
`timescale 1ns / 1ps
module hpack_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        code_byte,
    input  logic              final_byte,
    input  hpack_pkg::cmd_t   cmd,
    output hpack_pkg::sts_t   sts,
    output logic [1:0]        kind,
    output logic [7:0]        symbol,
    output logic              end_of_run
);
    import hpack_pkg::*;

    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              fin_reg, fin_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              disc_reg, disc_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        sym_reg, sym_next;
    logic              eor_reg, eor_next;
    logic [SYM_W:0]    hit;

    // Match the current pending word against the code table
    assign hit = code_lookup(pend_reg, cnt_reg);

    assign sts.disc     = disc_reg;
    assign sts.fin      = fin_reg;
    assign sts.match    = hit[SYM_W];
    assign sts.is_eos   = hit[SYM_W] && (hit[SYM_W-1:0] == SYM_W'(EOS_SYM));
    assign sts.full     = (cnt_reg >= CNT_W'(PEND_W));
    assign sts.last_bit = (bit_reg == '0);
    assign sts.pad_err  = (cnt_reg >= CNT_W'(PAD_MIN));

    // Next-state logic for the datapath registers
    always_comb
    begin
        byte_next = byte_reg;
        fin_next  = fin_reg;
        bit_next  = bit_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        disc_next = disc_reg;
        kind_next = kind_reg;
        sym_next  = sym_reg;
        eor_next  = eor_reg;
        if (cmd.load)
        begin
            byte_next = code_byte;
            fin_next  = final_byte;
            bit_next  = 3'd7;
        end
        if (cmd.clr)
        begin
            pend_next = '0;
            cnt_next  = '0;
        end
        else if (cmd.shift)
        begin
            pend_next = {pend_reg[PEND_W-2:0], byte_reg[bit_reg]};
            cnt_next  = cnt_reg + 1'b1;
            bit_next  = bit_reg - 1'b1;
        end
        if (cmd.set_disc)
            disc_next = 1'b1;
        else if (cmd.clr_disc)
            disc_next = 1'b0;
        if (cmd.out_load)
        begin
            kind_next = cmd.out_kind;
            sym_next  = cmd.use_sym ? hit[7:0] : 8'd0;
            eor_next  = (cmd.out_kind != KIND_SYMBOL);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
            disc_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            disc_reg <= disc_next;
            bit_reg  <= bit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        fin_reg  <= fin_next;
        kind_reg <= kind_next;
        sym_reg  <= sym_next;
        eor_reg  <= eor_next;
    end

    assign kind       = kind_reg;
    assign symbol     = sym_reg;
    assign end_of_run = eor_reg;

endmodule

FILE: rtl/hpack_ctrl.sv
// Controller of the HPACK Huffman decoder: sequences bit shifts, symbol
// emission and the end-of-string status. Depends on hpack_pkg.
`timescale 1ns / 1ps
module hpack_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_ready,
    input  hpack_pkg::sts_t sts,
    output hpack_pkg::cmd_t cmd,
    output logic            in_ready,
    output logic            out_valid
);
    import hpack_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   after_reg, after_next;  // return to SHIFT (1) or STATUS check (0)

    // Hold output valid until the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            after_reg <= after_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.out_kind = KIND_SYMBOL;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Drop bytes after EOS until the last one
                if (sts.disc)
                begin
                    if (sts.fin)
                    begin
                        cmd.clr_disc = 1'b1;
                        cmd.clr      = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    after_next = !sts.last_bit;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.match)
                begin
                    if (!ov_reg || out_ready)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.clr      = 1'b1;
                        ov_next      = 1'b1;
                        if (sts.is_eos)
                        begin
                            cmd.out_kind = KIND_EOS_ERR;
                            cmd.set_disc = !sts.fin;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cmd.use_sym = 1'b1;
                            state_next  = after_reg ? ST_SHIFT : ST_STATUS;
                        end
                    end
                end
                else
                begin
                    cmd.clr    = sts.full;
                    state_next = after_reg ? ST_SHIFT : ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (!sts.fin)
                    state_next = ST_IDLE;
                else if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = sts.pad_err ? KIND_PAD_ERR : KIND_DONE_OK;
                    cmd.clr      = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A result is loaded only while the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!ov_reg || out_ready))
        else $error("output overwritten");
    // Input accepted only when idle, and processing starts next cycle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SHIFT))
        else $error("load did not start shifting");
    // Discarding never coexists with a shift command
    a_disc_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.disc && state_reg == ST_SHIFT) |-> !cmd.shift)
        else $error("shift while discarding");
`endif

endmodule

FILE: rtl/hpack_huffman_decoder_core.sv
// HPACK Huffman decoder top level: one code byte in, decoded items out.
// Each code bit takes a shift state, then a table match (emit) state; a symbol is
// loaded in the emit state of the bit that completes it, a final byte's status in
// the status state after its last bit. A new byte is accepted only in idle; a byte
// dropped after EOS passes only the shift state. Output stalls hold the controller.
// Reset (rst_n, async, active low) clears the pending word and discard flag.
`timescale 1ns / 1ps
module hpack_huffman_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] kind, [9:2] symbol, [15:10] zero
    output logic        m_tlast    // end_of_run
);
    import hpack_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [1:0] kind;
    logic [7:0] symbol;

    hpack_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_tvalid && s_tready),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    hpack_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_byte  (s_tdata),
        .final_byte (s_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .symbol     (symbol),
        .end_of_run (m_tlast)
    );

    assign m_tdata = {6'd0, symbol, kind};

endmodule

FILE: test/hpack_huffman_decoder_core_test.sv
// Testbench for the HPACK Huffman decoder core: drives coded strings byte by
// byte and checks each decoded item against a behavioral decoder. Needs hpack_pkg.
`timescale 1ns / 1ps
module hpack_huffman_decoder_core_test;
    import hpack_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        kind_t      kind;
        logic [7:0] symbol;
        logic       eor;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // decoder state for prediction
    logic [29:0] pend_word;
    int          pend_len;
    logic        skip_rest;
    decoded_t    expected_q[$];
    int          fail_count;
    int          idle_cycles;
    bit          quiet;
    bit          rx_idle_en;

    // code table of RFC 7541 Appendix B, indexed by symbol
    logic [29:0] code_bits[257];
    int          code_len[257];

    // bit stream under construction for well-formed strings
    bit          stream[$];

    hpack_huffman_decoder_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int lookup_symbol(input logic [29:0] w, input int n);
        for (int s = 0; s < 257; s++)
        begin
            if (code_len[s] == n && code_bits[s] == w)
                return s;
        end
        return -1;
    endfunction

    function automatic void push_decoded(input kind_t k, input logic [7:0] s, input logic e);
        decoded_t d;
        d.kind = k;
        d.symbol = s;
        d.eor = e;
        expected_q.push_back(d);
    endfunction

    // predict the items caused by one accepted byte
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        int sym;
        if (skip_rest)
        begin
            if (fin)
            begin
                skip_rest = 1'b0;
                pend_word = '0;
                pend_len = 0;
            end
            return;
        end
        for (int i = 7; i >= 0; i--)
        begin
            pend_word = {pend_word[28:0], b[i]};
            if (pend_len < 31)
                pend_len++;
            sym = lookup_symbol(pend_word, pend_len);
            if (sym == EOS_SYM)
            begin
                push_decoded(KIND_EOS_ERR, 8'd0, 1'b1);
                pend_word = '0;
                pend_len = 0;
                if (!fin)
                    skip_rest = 1'b1;
                return;
            end
            if (sym >= 0)
            begin
                push_decoded(KIND_SYMBOL, sym[7:0], 1'b0);
                pend_word = '0;
                pend_len = 0;
            end
            else if (pend_len >= 30)
            begin
                pend_word = '0;
                pend_len = 0;
            end
        end
        if (fin)
        begin
            push_decoded(pend_len >= 8 ? KIND_PAD_ERR : KIND_DONE_OK, 8'd0, 1'b1);
            pend_word = '0;
            pend_len = 0;
        end
    endfunction

    // send one byte, with an optional random gap before it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 18)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, fin);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic void append_symbol(input int s);
        for (int i = code_len[s] - 1; i >= 0; i--)
            stream.push_back(code_bits[s][i]);
    endfunction

    // pack the bit stream into bytes, pad with ones (or random bits), send it;
    // mark the last byte as the end of the string only when asked
    task automatic send_stream(input bit random_pad, input bit close);
        logic [7:0] b;
        int nbytes;
        while (stream.size() % 8 != 0)
            stream.push_back(random_pad ? 1'($urandom) : 1'b1);
        nbytes = stream.size() / 8;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = stream[k * 8 + j];
            send_byte(b, close && (k == nbytes - 1));
        end
        stream.delete();
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // short codes, the longest codes, all-zero and all-one bytes
    task automatic test_directed();
        int syms[$] = '{48, 97, 116, 32, 0, 10, 13, 22, 255, 254, 128};
        foreach (syms[i])
            append_symbol(syms[i]);
        send_stream(1'b0, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // a whole pad byte of ones gives a padding error
        append_symbol(97);
        for (int i = 0; i < 11; i++)
            stream.push_back(1'b1);
        send_stream(1'b0, 1'b1);
        // EOS mid string, then bytes that are dropped up to the last one
        append_symbol(101);
        append_symbol(EOS_SYM);
        send_stream(1'b0, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        // EOS on the last byte of a string
        repeat (3) send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        wait_drained();
    endtask

    // coded strings with random content (some with EOS or long padding), plus raw noise strings
    task automatic test_random(input int n_items);
        int sent;
        int len;
        string common_chars;
        sent = 0;
        common_chars = "aeiost0129 ";
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 2) == 0)
                        append_symbol($urandom_range(0, 255));
                    else
                        append_symbol(int'(common_chars[$urandom_range(0, 10)]));
                end
                if ($urandom_range(0, 9) == 0)
                    append_symbol(EOS_SYM);
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(8, 14)) stream.push_back(1'b1);
                sent += (stream.size() + 7) / 8;
                send_stream(1'($urandom_range(0, 1)), 1'b1);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), i == len - 1);
                sent += len;
            end
        end
    endtask

    // receiver with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        decoded_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected item kind=%0d symbol=%0d", m_tdata[1:0], m_tdata[9:2]);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[1:0] !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[9:2] !== e.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", e.symbol, m_tdata[9:2]);
                    fail_count++;
                end
                if (m_tdata[15:10] !== 6'd0)
                begin
                    $error("pad: expected 0, got %0d", m_tdata[15:10]);
                    fail_count++;
                end
                if (m_tlast !== e.eor)
                begin
                    $error("end_of_run: expected %0d, got %0d", e.eor, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < 257; s++)
        begin
            code_bits[s] = CODE_VAL[s];
            code_len[s] = int'(CODE_LEN[s]);
        end
        pend_word = '0;
        pend_len = 0;
        skip_rest = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        rx_idle_en = 1'b1;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(100);
        quiet = 1'b1;
        rx_idle_en = 1'b0;
        test_random(25);
        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: files.f
rtl/hpack_pkg.sv
rtl/hpack_dp.sv
rtl/hpack_ctrl.sv
rtl/hpack_huffman_decoder_core.sv
test/hpack_huffman_decoder_core_test.sv
